[hw/rtl/gcsrq_pkg.sv]
// Package for the grid cell staircase rank query block.
// Holds store depths, input kind codes and the request/response word types.
// No dependencies.
package gcsrq_pkg;

   localparam int X_DEPTH      = 64;
   localparam int Y_DEPTH      = 64;
   localparam int CELL_DEPTH   = X_DEPTH * Y_DEPTH + 1;
   localparam int FACTOR_DEPTH = 1024;
   localparam int PIECE_DEPTH  = 4096;
   localparam int CORNER_DEPTH = 16384;
   localparam logic [12:0] RANK_MAX = 13'd8191;

   localparam logic [2:0] KIND_X_BREAK   = 3'd0;
   localparam logic [2:0] KIND_Y_BREAK   = 3'd1;
   localparam logic [2:0] KIND_CELL      = 3'd2;
   localparam logic [2:0] KIND_FACTOR    = 3'd3;
   localparam logic [2:0] KIND_PIECE     = 3'd4;
   localparam logic [2:0] KIND_CORNER    = 3'd5;
   localparam logic [2:0] KIND_QUERY     = 3'd6;

   localparam logic CSR_X_COUNT = 1'b0;
   localparam logic CSR_Y_COUNT = 1'b1;

   typedef struct packed {
      logic [2:0]         kind;
      logic [14:0]        index;
      logic signed [31:0] word_a;
      logic signed [31:0] word_b;
      logic signed [31:0] theta;
      logic signed [31:0] source_x;
      logic signed [31:0] source_y;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
   } req_type;

   typedef struct packed {
      logic [12:0] rank;
      logic        source_in_grid;
   } rsp_type;

endpackage

[hw/rtl/gcsrq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gcsrq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/grid_cell_staircase_rank_query.sv]
// Top level of the grid cell staircase rank query block.
// Uses gcsrq_pkg and gcsrq_ram (seven table stores).
//
// A load (kinds 0 to 5) is written at the edge that accepts it and busy stays low. A query
// holds busy while one sequencer walks the stores, one read per cycle: it scans the x and y
// breakpoints together for the source cell, reads the cell's factor range, then checks each
// factor's slope against theta; per qualifying factor it reads the piece range, and per piece
// the corner range, scanning corners up to and including the first one at or below the
// target, then closes the cell and the query. A query outside the grid or with the target
// below the source goes from the scans straight to the done state. The rank word appears on
// rsp_* for exactly one cycle with rsp_valid high, in the first cycle that busy is low; it
// cannot be stalled.
module grid_cell_staircase_rank_query (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gcsrq_pkg::req_type req_data,
   output logic              rsp_valid,
   output gcsrq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [6:0]        csr_data
);
   import gcsrq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AXIS, ST_C0, ST_C1, ST_F0, ST_F1, ST_P0, ST_P1, ST_K, ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [6:0]         x_count_ff, y_count_ff;
   logic signed [31:0] theta_ff, sx_ff, sy_ff, tx_ff, ty_ff;
   logic [6:0]         xi_ff, xi_in, yi_ff, yi_in;
   logic [12:0]        ci_ff, ci_in;
   logic [10:0]        fi_ff, fi_in, fa_ff, fa_in, flo_ff, flo_in, fhi_ff, fhi_in;
   logic [12:0]        pj_ff, pj_in, pa_ff, pa_in, phi_ff, phi_in;
   logic [14:0]        ki_ff, ki_in, khi_ff, khi_in, klo_ff, klo_in;
   logic [12:0]        rank_ff, rank_in;
   logic               grid_ff, grid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [6:0]  xc, yc;
   logic        accept, is_query;
   logic [31:0] x_rd, y_rd, slope_rd;
   logic [10:0] cell_rd;
   logic [12:0] fps_rd;
   logic [14:0] pcs_rd;
   logic [63:0] corner_rd;
   logic        xgo, ygo, dom;
   logic [12:0] cell_idx;
   logic [10:0] cell_clamp;
   logic [12:0] fps_clamp;
   logic [14:0] pcs_clamp;
   logic [12:0] rank_inc;

   assign accept   = start && !busy;
   assign is_query = req_data.kind == KIND_QUERY;
   assign busy     = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   assign xc = (x_count_ff == 7'd0) ? 7'd1 :
               (x_count_ff > 7'(X_DEPTH)) ? 7'(X_DEPTH) : x_count_ff;
   assign yc = (y_count_ff == 7'd0) ? 7'd1 :
               (y_count_ff > 7'(Y_DEPTH)) ? 7'(Y_DEPTH) : y_count_ff;

   gcsrq_ram #(.DEPTH(X_DEPTH), .WIDTH(32)) u_x_axis (
      .clock, .wr_en(accept && req_data.kind == KIND_X_BREAK && req_data.index < 15'(X_DEPTH)),
      .wr_addr(req_data.index[5:0]), .wr_data(req_data.word_a),
      .rd_addr(xi_in[5:0]), .rd_data(x_rd));

   gcsrq_ram #(.DEPTH(Y_DEPTH), .WIDTH(32)) u_y_axis (
      .clock, .wr_en(accept && req_data.kind == KIND_Y_BREAK && req_data.index < 15'(Y_DEPTH)),
      .wr_addr(req_data.index[5:0]), .wr_data(req_data.word_a),
      .rd_addr(yi_in[5:0]), .rd_data(y_rd));

   gcsrq_ram #(.DEPTH(CELL_DEPTH), .WIDTH(11)) u_cell (
      .clock, .wr_en(accept && req_data.kind == KIND_CELL && req_data.index < 15'(CELL_DEPTH)),
      .wr_addr(req_data.index[12:0]), .wr_data(req_data.word_a[10:0]),
      .rd_addr(ci_in), .rd_data(cell_rd));

   gcsrq_ram #(.DEPTH(FACTOR_DEPTH), .WIDTH(32)) u_slope (
      .clock,
      .wr_en(accept && req_data.kind == KIND_FACTOR && req_data.index < 15'(FACTOR_DEPTH)),
      .wr_addr(req_data.index[9:0]), .wr_data(req_data.word_a),
      .rd_addr(fi_in[9:0]), .rd_data(slope_rd));

   gcsrq_ram #(.DEPTH(FACTOR_DEPTH + 1), .WIDTH(13)) u_fps (
      .clock,
      .wr_en(accept && req_data.kind == KIND_FACTOR && req_data.index < 15'(FACTOR_DEPTH + 1)),
      .wr_addr(req_data.index[10:0]), .wr_data(req_data.word_b[12:0]),
      .rd_addr(fa_in), .rd_data(fps_rd));

   gcsrq_ram #(.DEPTH(PIECE_DEPTH + 1), .WIDTH(15)) u_pcs (
      .clock,
      .wr_en(accept && req_data.kind == KIND_PIECE && req_data.index < 15'(PIECE_DEPTH + 1)),
      .wr_addr(req_data.index[12:0]), .wr_data(req_data.word_a[14:0]),
      .rd_addr(pa_in), .rd_data(pcs_rd));

   gcsrq_ram #(.DEPTH(CORNER_DEPTH), .WIDTH(64)) u_corner (
      .clock,
      .wr_en(accept && req_data.kind == KIND_CORNER && req_data.index < 15'(CORNER_DEPTH)),
      .wr_addr(req_data.index[13:0]), .wr_data({req_data.word_b, req_data.word_a}),
      .rd_addr(ki_in[13:0]), .rd_data(corner_rd));

   assign xgo = (xi_ff < xc) && ($signed(x_rd) <= sx_ff);
   assign ygo = (yi_ff < yc) && ($signed(y_rd) <= sy_ff);
   assign dom = ($signed(corner_rd[31:0]) <= tx_ff) && ($signed(corner_rd[63:32]) <= ty_ff);
   assign cell_idx = 13'(6'(yi_ff - 7'd1) * xc) + 13'(6'(xi_ff - 7'd1));
   assign cell_clamp = (cell_rd > 11'(FACTOR_DEPTH)) ? 11'(FACTOR_DEPTH) : cell_rd;
   assign fps_clamp  = (fps_rd > 13'(PIECE_DEPTH)) ? 13'(PIECE_DEPTH) : fps_rd;
   assign pcs_clamp  = (pcs_rd > 15'(CORNER_DEPTH)) ? 15'(CORNER_DEPTH) : pcs_rd;
   assign rank_inc   = (rank_ff == RANK_MAX) ? rank_ff : rank_ff + 13'd1;

   always_comb begin
      state_in     = state_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      ci_in        = ci_ff;
      fi_in        = fi_ff;
      fa_in        = fa_ff;
      flo_in       = flo_ff;
      fhi_in       = fhi_ff;
      pj_in        = pj_ff;
      pa_in        = pa_ff;
      phi_in       = phi_ff;
      ki_in        = ki_ff;
      klo_in       = klo_ff;
      khi_in       = khi_ff;
      rank_in      = rank_ff;
      grid_in      = grid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            xi_in   = '0;
            yi_in   = '0;
            rank_in = '0;
            if (accept && is_query) begin
               state_in = ST_AXIS;
            end
         end
         ST_AXIS: begin
            if (xgo) xi_in = xi_ff + 7'd1;
            if (ygo) yi_in = yi_ff + 7'd1;
            if (!xgo && !ygo) begin
               grid_in = (xi_ff != 7'd0) && (yi_ff != 7'd0);
               if (!grid_in || tx_ff < sx_ff || ty_ff < sy_ff) begin
                  state_in = ST_DONE;
               end else begin
                  ci_in    = cell_idx;
                  state_in = ST_C0;
               end
            end
         end
         ST_C0: begin
            flo_in   = cell_clamp;
            ci_in    = ci_ff + 13'd1;
            state_in = ST_C1;
         end
         ST_C1: begin
            fhi_in   = cell_clamp;
            fi_in    = flo_ff;
            fa_in    = flo_ff;
            state_in = ST_F0;
         end
         ST_F0: begin
            if (fi_ff >= fhi_ff) begin
               state_in = ST_DONE;
            end else if ($signed(slope_rd) < theta_ff) begin
               fi_in = fi_ff + 11'd1;
               fa_in = fi_ff + 11'd1;
            end else begin
               pj_in    = fps_clamp;
               fa_in    = fi_ff + 11'd1;
               state_in = ST_F1;
            end
         end
         ST_F1: begin
            phi_in   = fps_clamp;
            pa_in    = pj_ff;
            state_in = ST_P0;
         end
         ST_P0: begin
            if (pj_ff >= phi_ff) begin
               fi_in    = fi_ff + 11'd1;
               fa_in    = fi_ff + 11'd1;
               state_in = ST_F0;
            end else begin
               klo_in   = pcs_clamp;
               pa_in    = pj_ff + 13'd1;
               state_in = ST_P1;
            end
         end
         ST_P1: begin
            khi_in = pcs_clamp;
            if (pcs_clamp <= klo_ff) begin
               rank_in  = rank_inc;
               pj_in    = pj_ff + 13'd1;
               pa_in    = pj_ff + 13'd1;
               state_in = ST_P0;
            end else begin
               ki_in    = klo_ff;
               state_in = ST_K;
            end
         end
         ST_K: begin
            if (dom) begin
               pj_in    = pj_ff + 13'd1;
               pa_in    = pj_ff + 13'd1;
               state_in = ST_P0;
            end else if (ki_ff + 15'd1 >= khi_ff) begin
               rank_in  = rank_inc;
               pj_in    = pj_ff + 13'd1;
               pa_in    = pj_ff + 13'd1;
               state_in = ST_P0;
            end else begin
               ki_in = ki_ff + 15'd1;
            end
         end
         ST_DONE: begin
            rsp_valid_in          = 1'b1;
            rsp_in.rank           = rank_ff;
            rsp_in.source_in_grid = grid_ff;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x_count_ff   <= 7'd1;
         y_count_ff   <= 7'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready && csr_index == CSR_X_COUNT) x_count_ff <= csr_data;
         if (csr_valid && csr_ready && csr_index == CSR_Y_COUNT) y_count_ff <= csr_data;
      end
      if (accept && is_query) begin
         theta_ff <= req_data.theta;
         sx_ff    <= req_data.source_x;
         sy_ff    <= req_data.source_y;
         tx_ff    <= req_data.target_x;
         ty_ff    <= req_data.target_y;
      end
      xi_ff   <= xi_in;
      yi_ff   <= yi_in;
      ci_ff   <= ci_in;
      fi_ff   <= fi_in;
      fa_ff   <= fa_in;
      flo_ff  <= flo_in;
      fhi_ff  <= fhi_in;
      pj_ff   <= pj_in;
      pa_ff   <= pa_in;
      phi_ff  <= phi_in;
      ki_ff   <= ki_in;
      klo_ff  <= klo_in;
      khi_ff  <= khi_in;
      rank_ff <= rank_in;
      grid_ff <= grid_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response longer than one cycle");
   a_rank_grid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.rank != 13'd0) |-> rsp_data.source_in_grid)
      else $error("nonzero rank outside grid");
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == KIND_QUERY) |=> busy)
      else $error("query accepted without busy");

endmodule

[dv/grid_cell_staircase_rank_query_checker.sv]
// Checker for the grid cell staircase rank query block.
// Mirrors the table stores and counts, predicts each query's rank word and compares.
// Depends on gcsrq_pkg.
module grid_cell_staircase_rank_query_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  gcsrq_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  gcsrq_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic               csr_index,
   input  logic [6:0]         csr_data,
   output int                 fail_count,
   output int                 pending
);
   import gcsrq_pkg::*;

   logic [6:0]         x_count, y_count;
   logic signed [31:0] x_break [X_DEPTH];
   logic signed [31:0] y_break [Y_DEPTH];
   int                 cell_base [CELL_DEPTH];
   logic signed [31:0] slope [FACTOR_DEPTH];
   int                 piece_base [FACTOR_DEPTH + 1];
   int                 corner_base [PIECE_DEPTH + 1];
   logic signed [31:0] corner_x [CORNER_DEPTH];
   logic signed [31:0] corner_y [CORNER_DEPTH];
   rsp_type            rank_queue [$];

   function automatic int clip(int v, int lim);
      return v > lim ? lim : v;
   endfunction

   function automatic rsp_type predict_rank(req_type r);
      int xc, yc, px, py, cell_id, total, lo, hi, clo, chi;
      bit blocked;
      rsp_type w;
      xc = (x_count == 0) ? 1 : clip(int'(x_count), X_DEPTH);
      yc = (y_count == 0) ? 1 : clip(int'(y_count), Y_DEPTH);
      px = 0;
      while (px < xc && x_break[px] <= r.source_x) px++;
      py = 0;
      while (py < yc && y_break[py] <= r.source_y) py++;
      total = 0;
      w.source_in_grid = (px > 0 && py > 0);
      if (w.source_in_grid && r.target_x >= r.source_x && r.target_y >= r.source_y) begin
         cell_id = (py - 1) * xc + (px - 1);
         for (int f = clip(cell_base[cell_id], FACTOR_DEPTH);
              f < clip(cell_base[cell_id + 1], FACTOR_DEPTH); f++) begin
            if (slope[f] < r.theta) continue;
            lo = clip(piece_base[f], PIECE_DEPTH);
            hi = clip(piece_base[f + 1], PIECE_DEPTH);
            for (int p = lo; p < hi; p++) begin
               clo = clip(corner_base[p], CORNER_DEPTH);
               chi = clip(corner_base[p + 1], CORNER_DEPTH);
               blocked = 0;
               for (int c = clo; c < chi && !blocked; c++)
                  if (corner_x[c] <= r.target_x && corner_y[c] <= r.target_y) blocked = 1;
               if (!blocked) total++;
            end
         end
      end
      w.rank = (total > RANK_MAX) ? RANK_MAX : total[12:0];
      return w;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         x_count = 1;
         y_count = 1;
         rank_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_X_COUNT) x_count = csr_data;
            else y_count = csr_data;
         end
         if (rsp_valid) begin
            if (rank_queue.size() == 0) begin
               $display("%0t: unexpected word expected none actual rank=%0d in_grid=%0d",
                        $time, rsp_data.rank, rsp_data.source_in_grid);
               fail_count++;
            end else begin
               want = rank_queue.pop_front();
               if (rsp_data.rank !== want.rank) begin
                  $display("%0t: rank expected %0d actual %0d",
                           $time, want.rank, rsp_data.rank);
                  fail_count++;
               end
               if (rsp_data.source_in_grid !== want.source_in_grid) begin
                  $display("%0t: source_in_grid expected %0d actual %0d",
                           $time, want.source_in_grid, rsp_data.source_in_grid);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            case (req_data.kind)
               KIND_X_BREAK:
                  if (req_data.index < X_DEPTH) x_break[req_data.index[5:0]] = req_data.word_a;
               KIND_Y_BREAK:
                  if (req_data.index < Y_DEPTH) y_break[req_data.index[5:0]] = req_data.word_a;
               KIND_CELL:
                  if (req_data.index < CELL_DEPTH)
                     cell_base[req_data.index[12:0]] = int'(req_data.word_a[10:0]);
               KIND_FACTOR: begin
                  if (req_data.index < FACTOR_DEPTH)
                     slope[req_data.index[9:0]] = req_data.word_a;
                  if (req_data.index < FACTOR_DEPTH + 1)
                     piece_base[req_data.index[10:0]] = int'(req_data.word_b[12:0]);
               end
               KIND_PIECE:
                  if (req_data.index < PIECE_DEPTH + 1)
                     corner_base[req_data.index[12:0]] = int'(req_data.word_a[14:0]);
               KIND_CORNER:
                  if (req_data.index < CORNER_DEPTH) begin
                     corner_x[req_data.index[13:0]] = req_data.word_a;
                     corner_y[req_data.index[13:0]] = req_data.word_b;
                  end
               KIND_QUERY: rank_queue = {rank_queue, predict_rank(req_data)};
               default: ;
            endcase
         end
      end
      pending = rank_queue.size();
   end

endmodule

[dv/testbench.sv]
// Top of the grid cell staircase rank query testbench.
// Fills the table, runs directed and random loads, queries and count settings.
// Depends on gcsrq_pkg, the block and grid_cell_staircase_rank_query_checker.
module testbench;
   import gcsrq_pkg::*;

   localparam logic [2:0] KIND_NONE = 3'd7;
   localparam int IDLE_LIMIT = 400000;

   logic       clock = 0;
   logic       reset = 1;
   logic       start = 0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid = 0;
   logic       csr_ready;
   logic       csr_index = CSR_X_COUNT;
   logic [6:0] csr_data = 0;
   int         fail_count, pending;
   int         gap_pct = 0;
   int         idle_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   grid_cell_staircase_rank_query u_top (.*);

   grid_cell_staircase_rank_query_checker u_checker (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] q16(int whole);
      return (whole <<< 16) | $urandom_range(0, 65535);
   endfunction

   function automatic req_type random_req();
      logic [255:0] noise;
      noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom()};
      return noise[$bits(req_type)-1:0];
   endfunction

   task automatic send(req_type r);
      if ($urandom_range(0, 99) < gap_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic load(logic [2:0] kind, int index, logic [31:0] a, logic [31:0] b);
      req_type r;
      r = random_req();
      r.kind = kind;
      r.index = 15'(index);
      r.word_a = a;
      r.word_b = b;
      send(r);
   endtask

   task automatic query(int th, int sx, int sy, int tx, int ty);
      req_type r;
      r = random_req();
      r.kind = KIND_QUERY;
      r.theta = th;
      r.source_x = sx;
      r.source_y = sy;
      r.target_x = tx;
      r.target_y = ty;
      send(r);
   endtask

   task automatic drain();
      start <= 0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [6:0] v);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   function automatic int offset_word(int base, int width);
      int v;
      v = (base + $urandom_range(0, 6) - 3) & ((1 << width) - 1);
      return ($urandom() & ~((1 << width) - 1)) | v;
   endfunction

   task automatic random_load();
      logic [2:0] k;
      int idx;
      k = 3'($urandom_range(0, 5));
      case (k)
         KIND_X_BREAK, KIND_Y_BREAK: begin
            idx = $urandom_range(0, 63);
            load(k, idx, ($urandom_range(0, 4) == 0) ? $urandom() : q16(idx - 32), $urandom());
         end
         KIND_CELL: begin
            idx = $urandom_range(0, CELL_DEPTH - 1);
            load(k, idx, offset_word((idx * 3) % 1024, 11), $urandom());
         end
         KIND_FACTOR: begin
            idx = $urandom_range(0, FACTOR_DEPTH);
            load(k, idx, ($urandom_range(0, 9) == 0) ? $urandom() : q16($urandom_range(0, 16) - 8),
                 offset_word((idx * 4) % 4096, 13));
         end
         KIND_PIECE: begin
            idx = $urandom_range(0, PIECE_DEPTH);
            load(k, idx, offset_word((idx * 4) % 16384, 15), $urandom());
         end
         default: begin
            idx = $urandom_range(0, CORNER_DEPTH - 1);
            load(KIND_CORNER, idx,
                 ($urandom_range(0, 9) == 0) ? $urandom() : q16($urandom_range(0, 80) - 40),
                 ($urandom_range(0, 9) == 0) ? $urandom() : q16($urandom_range(0, 80) - 40));
         end
      endcase
   endtask

   task automatic random_query();
      int sx, sy, tx, ty, th;
      sx = ($urandom_range(0, 9) == 0) ? $urandom() : q16($urandom_range(0, 69) - 35);
      sy = ($urandom_range(0, 9) == 0) ? $urandom() : q16($urandom_range(0, 69) - 35);
      tx = sx + $urandom_range(0, 20 << 16);
      ty = sy + $urandom_range(0, 20 << 16);
      case ($urandom_range(0, 9))
         0: tx = sx - $urandom_range(1, 3 << 16);
         1: ty = sy - $urandom_range(1, 3 << 16);
         2: begin
            tx = $urandom();
            ty = $urandom();
         end
         default: ;
      endcase
      th = ($urandom_range(0, 4) == 0) ? $urandom() : q16($urandom_range(0, 18) - 9);
      query(th, sx, sy, tx, ty);
   endtask

   initial begin
      int xs [6], ys [6];
      int per_phase, done;
      xs = '{64, 1, 0, 127, 7, 0};
      ys = '{64, 1, 127, 0, 9, 0};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int i = 0; i < X_DEPTH; i++) load(KIND_X_BREAK, i, (i - 32) <<< 16, $urandom());
      for (int i = 0; i < Y_DEPTH; i++) load(KIND_Y_BREAK, i, (i - 32) <<< 16, $urandom());
      for (int i = 0; i < CELL_DEPTH; i++) load(KIND_CELL, i, (i * 3) % 1024, 0);
      for (int i = 0; i <= FACTOR_DEPTH; i++)
         load(KIND_FACTOR, i, q16($urandom_range(0, 16) - 8), (i * 4) % 4096);
      for (int i = 0; i <= PIECE_DEPTH; i++) load(KIND_PIECE, i, (i * 4) % 16384, 0);
      for (int i = 0; i < CORNER_DEPTH; i++)
         load(KIND_CORNER, i, q16($urandom_range(0, 80) - 40), q16($urandom_range(0, 80) - 40));

      write_csr(CSR_X_COUNT, 7'd64);
      write_csr(CSR_Y_COUNT, 7'd64);
      query(0, 32'sh8000_0000, 0, 32'sh7fff_ffff, 32'sh7fff_ffff);
      query(0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
      query(0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      query(32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff);
      query(32'sh7fff_ffff, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff);
      query(32'sh8000_0000, 3 <<< 16, 3 <<< 16, (3 <<< 16) - 1, 8 <<< 16);
      query(32'sh8000_0000, 3 <<< 16, 3 <<< 16, 8 <<< 16, (3 <<< 16) - 1);
      query(32'sh8000_0000, -(32 <<< 16), -(32 <<< 16), -(32 <<< 16), -(32 <<< 16));
      query(32'sh8000_0000, -(32 <<< 16) - 1, 0, 5 <<< 16, 5 <<< 16);
      load(KIND_NONE, 5, $urandom(), $urandom());
      load(KIND_X_BREAK, 32767, 0, 0);
      load(KIND_CORNER, CORNER_DEPTH, 0, 0);
      load(KIND_FACTOR, FACTOR_DEPTH, 32'sh7fff_ffff, 32'hffff_e000 | 4096);
      // whole piece list under one factor of cell 0
      load(KIND_CELL, 1, 1, 0);
      load(KIND_FACTOR, 0, 32'sh8000_0000, 0);
      load(KIND_FACTOR, 1, 0, 4096);
      query(32'sh8000_0000, -(32 <<< 16), -(32 <<< 16), 0, 0);
      load(KIND_FACTOR, 1, 0, 4);
      load(KIND_FACTOR, 0, 0, 0);
      load(KIND_CELL, 1, 3, 0);
      load(KIND_FACTOR, FACTOR_DEPTH, 0, 0);

      per_phase = 340;
      done = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_X_COUNT, 7'((ph == 5) ? $urandom_range(0, 127) : xs[ph]));
         write_csr(CSR_Y_COUNT, 7'((ph == 5) ? $urandom_range(0, 127) : ys[ph]));
         for (int n = 0; n < per_phase; n++) begin
            gap_pct = (done < 680) ? 13 : (done < 1360) ? 53 : 0;
            case ($urandom_range(0, 19))
               0: load(KIND_NONE, $urandom(), $urandom(), $urandom());
               1: load(3'($urandom_range(0, 5)), $urandom_range(16384, 32767), $urandom(),
                       $urandom());
               2, 3, 4, 5, 6, 7, 8: random_load();
               default: random_query();
            endcase
            done++;
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

endmodule

[grid_cell_staircase_rank_query.f]
hw/rtl/gcsrq_pkg.sv
hw/rtl/gcsrq_ram.sv
hw/rtl/grid_cell_staircase_rank_query.sv
dv/grid_cell_staircase_rank_query_checker.sv
dv/testbench.sv
